### rtl/matrix_multiply_engine_unit_macros.svh
// Assertion macros for the matrix multiply engine RTL.
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MME_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MME_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/mme_pkg.sv
// Shared types, codes and widths of the matrix multiply engine.
package mme_pkg;

  // Fixed field widths of the channels.
  localparam int MODE_W      = 2;
  localparam int POS_W       = 3;
  localparam int VALUE_W     = 16;
  localparam int PRODUCT_W   = 35;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  // Parameter defaults.
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_DATA_WIDTH = 16;

  // Reset value of every size register.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // Item operation codes.
  localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    MME_IDLE,
    MME_MAC,
    MME_WAIT
  } mme_state_t;

endpackage

### rtl/mme_if.sv
// Channel interfaces of the matrix multiply engine: input, result and configuration.

// Input channel: element writes and compute requests.
interface mme_in_if import mme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [POS_W-1:0]          row;
  logic [POS_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink (input valid, input mode, input row, input col, input value,
                output ready);
endinterface

// Result channel: one product element per transfer.
interface mme_out_if import mme_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [POS_W-1:0]            out_row;
  logic [POS_W-1:0]            out_col;
  logic signed [PRODUCT_W-1:0] product;
  logic                        mismatch;
  logic                        last;

  modport source (output valid, output out_row, output out_col, output product,
                  output mismatch, output last, input ready);
  modport sink (input valid, input out_row, input out_col, input product,
                input mismatch, input last, output ready);
endinterface

// Configuration write channel.
interface mme_cfg_if import mme_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mme_store.sv
// Element store: one write port, one registered read port, entries read as zero until written.
module mme_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  rd_vld_r;

  // Written flags, cleared at reset so the store reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Memory array with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine: sequencer, shared multiply-accumulate and output.
//
//  channel  | direction | handshake    | payload
//  ---------+-----------+--------------+-------------------------------------------
//  in_ch    | in        | valid/ready  | mode, row, col, value
//  out_ch   | out       | valid/ready  | out_row, out_col, product, mismatch, last
//  cfg_ch   | in        | valid/ready  | index, data (ready is always high)
//
// Element writes can follow each other every cycle while no compute run is in progress.
// A compute item walks the result elements one at a time through one shared multiplier;
// each element waits for the output to be taken before the next one starts.
// A size mismatch gives its result in the cycle after the compute item is accepted.
// The input is not ready while a compute run is in progress.
// Reset is synchronous; the stores read as zero right after reset with no clearing pass.
module matrix_multiply_engine_unit
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  mme_in_if.sink   in_ch,
  mme_out_if.source out_ch,
  mme_cfg_if.sink  cfg_ch
);

  `include "matrix_multiply_engine_unit_macros.svh"

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam logic [ADDR_W-1:0]     DIM_ADDR = ADDR_W'(MAX_DIM);
  localparam logic [CFG_DATA_W-1:0] DIM_CFG  = CFG_DATA_W'(MAX_DIM);
  localparam logic [POS_W:0]        DIM_POS  = (POS_W + 1)'(MAX_DIM);

  // Map a size register onto 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_adj(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_CFG) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  // Size registers.
  logic [CFG_DATA_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [DIM_W-1:0]      ar_dim, ac_dim, br_dim, bc_dim;

  // Sequencer.
  mme_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic             in_ready, in_acc, is_comp, dim_bad;
  logic             issue, load_mism, out_take;
  logic             k_last, r_last, c_last;

  // Stores.
  logic                  wr_pos_ok;
  logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_WIDTH-1:0] wr_data, a_data, b_data;

  // Multiply-accumulate pipeline.
  logic                        s1_vld_r, s1_first_r, s1_last_r;
  logic                        s2_vld_r, s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [PRODUCT_W-1:0] prod_ext, sum, acc_r;

  // Output register.
  logic                        out_vld_r, out_mism_r, out_last_r;
  logic [POS_W-1:0]            out_row_r, out_col_r;
  logic signed [PRODUCT_W-1:0] out_prod_r;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_A_ROWS: a_rows_r <= cfg_ch.data;
        CFG_A_COLS: a_cols_r <= cfg_ch.data;
        CFG_B_ROWS: b_rows_r <= cfg_ch.data;
        CFG_B_COLS: b_cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign ar_dim  = dim_adj(a_rows_r);
  assign ac_dim  = dim_adj(a_cols_r);
  assign br_dim  = dim_adj(b_rows_r);
  assign bc_dim  = dim_adj(b_cols_r);
  assign dim_bad = (ac_dim != br_dim);

  // Input decode.
  assign in_ready    = (state_r == MME_IDLE);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign is_comp     = (in_ch.mode == MODE_COMP);
  assign wr_pos_ok   = ({1'b0, in_ch.row} < DIM_POS) && ({1'b0, in_ch.col} < DIM_POS);
  assign wr_addr     = ADDR_W'(in_ch.row[IDX_W-1:0]) * DIM_ADDR
                     + ADDR_W'(in_ch.col[IDX_W-1:0]);
  assign wr_data     = DATA_WIDTH'(in_ch.value);

  // Walk positions.
  assign k_last   = (DIM_W'(k_r) == ac_dim - DIM_W'(1));
  assign r_last   = (DIM_W'(r_r) == ar_dim - DIM_W'(1));
  assign c_last   = (DIM_W'(c_r) == bc_dim - DIM_W'(1));
  assign out_take = out_vld_r && out_ch.ready;

  // Sequencer state register and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MME_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state: issue one inner-index read per cycle, then wait for the element to leave.
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    load_mism = 1'b0;
    case (state_r)
      MME_IDLE: begin
        if (in_acc && is_comp) begin
          if (dim_bad) begin
            load_mism = 1'b1;
          end
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = dim_bad ? MME_WAIT : MME_MAC;
        end
      end
      MME_MAC: begin
        issue = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = MME_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      MME_WAIT: begin
        if (out_take) begin
          if (out_last_r) begin
            state_nxt = MME_IDLE;
          end else begin
            state_nxt = MME_MAC;
            if (c_last) begin
              c_nxt = '0;
              r_nxt = r_r + IDX_W'(1);
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = MME_IDLE;
    endcase
  end

  // Read addresses: A[r][k] and B[k][c].
  assign rd_addr_a = ADDR_W'(r_r) * DIM_ADDR + ADDR_W'(k_r);
  assign rd_addr_b = ADDR_W'(k_r) * DIM_ADDR + ADDR_W'(c_r);

  mme_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && wr_pos_ok && (in_ch.mode == MODE_WR_A)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr_a),
    .rd_data (a_data)
  );

  mme_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && wr_pos_ok && (in_ch.mode == MODE_WR_B)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr_b),
    .rd_data (b_data)
  );

  // Pipeline control flags follow the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Shared multiplier, registered before the accumulate.
  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= k_last;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    if (s1_vld_r) begin
      prod_r <= $signed(a_data) * $signed(b_data);
    end
  end

  // Accumulate at full width; the first term restarts the sum.
  assign prod_ext = PRODUCT_W'(prod_r);
  assign sum      = s2_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_r <= sum;
    end
  end

  // Output register: filled by the last accumulate or by a size mismatch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_mism || (s2_vld_r && s2_last_r)) begin
      out_vld_r <= 1'b1;
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mism) begin
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_prod_r <= '0;
      out_mism_r <= 1'b1;
      out_last_r <= 1'b1;
    end else if (s2_vld_r && s2_last_r) begin
      out_row_r  <= POS_W'(r_r);
      out_col_r  <= POS_W'(c_r);
      out_prod_r <= sum;
      out_mism_r <= 1'b0;
      out_last_r <= r_last && c_last;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_row  = out_row_r;
  assign out_ch.out_col  = out_col_r;
  assign out_ch.product  = out_prod_r;
  assign out_ch.mismatch = out_mism_r;
  assign out_ch.last     = out_last_r;

  // Checks on the sequencer and the pipeline.
  `MME_ASSERT_IMP(a_idle_empty, clk, rst_n, in_ready, !out_vld_r && !s1_vld_r && !s2_vld_r, "input ready while work is still in flight")
  `MME_ASSERT_IMP(a_mism_form, clk, rst_n, out_vld_r && out_mism_r, out_last_r && (out_prod_r == '0), "mismatch result is not a lone zero result")
  `MME_ASSERT_NXT(a_mism_load, clk, rst_n, in_acc && is_comp && dim_bad, out_vld_r && out_mism_r, "size mismatch did not give its result")
  `MME_ASSERT_NXT(a_elem_done, clk, rst_n, s2_vld_r && s2_last_r, out_vld_r && !out_mism_r && (state_r == MME_WAIT), "finished element did not reach the output")

endmodule

### sim/testbench.sv
// Self-checking testbench for the matrix multiply engine: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import mme_pkg::*;

  localparam int MAX_DIM = DEF_MAX_DIM;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 4000000;

  // One product element as it leaves the block.
  typedef struct packed {
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
    logic signed [PRODUCT_W-1:0] product;
    logic                        mismatch;
    logic                        last;
  } product_t;

  // One row of the directed table: a register write or an item.
  typedef struct {
    bit                  is_cfg;
    logic [MODE_W-1:0]   code;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    product_t            want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();
  mme_cfg_if cfg_ch ();

  matrix_multiply_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the element stores and size registers.
  logic signed [VALUE_W-1:0] elem_a [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] elem_b [MAX_DIM*MAX_DIM];
  logic [CFG_DATA_W-1:0] size_ar, size_ac, size_br, size_bc;

  product_t products_due [$];
  int  fail_count = 0;
  int  n_items = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Size register value as the block uses it.
  function automatic int eff_dim(input logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  // Queue every product element that a compute item produces.
  task automatic queue_products();
    int ar, ac, br, bc;
    longint acc;
    product_t p;
    ar = eff_dim(size_ar);
    ac = eff_dim(size_ac);
    br = eff_dim(size_br);
    bc = eff_dim(size_bc);
    if (ac != br) begin
      p = '{row: '0, col: '0, product: '0, mismatch: 1'b1, last: 1'b1};
      products_due.push_back(p);
      return;
    end
    for (int r = 0; r < ar; r++) begin
      for (int c = 0; c < bc; c++) begin
        acc = 0;
        for (int k = 0; k < ac; k++)
          acc += longint'(elem_a[r*MAX_DIM+k]) * longint'(elem_b[k*MAX_DIM+c]);
        p.row = POS_W'(r);
        p.col = POS_W'(c);
        p.product = acc[PRODUCT_W-1:0];
        p.mismatch = 1'b0;
        p.last = (r == ar - 1) && (c == bc - 1);
        products_due.push_back(p);
      end
    end
  endtask

  // Apply one accepted item to the mirrored state.
  task automatic apply_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [VALUE_W-1:0] value);
    case (mode)
      MODE_WR_A: elem_a[row*MAX_DIM+col] = value;
      MODE_WR_B: elem_b[row*MAX_DIM+col] = value;
      MODE_COMP: queue_products();
      default: ;
    endcase
  endtask

  // Offer one item, wait for it to be taken, then maybe leave a gap.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic [VALUE_W-1:0] value,
                           input bit typed, input product_t want);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) products_due.push_back(want);
    else apply_item(mode, row, col, value);
    if (mode != MODE_UNUSED) n_items++;
    if (n_items > 400) quiet = 1'b1;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write a size register once the block has gone idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (products_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_A_ROWS: size_ar = data;
      CFG_A_COLS: size_ac = data;
      CFG_B_ROWS: size_br = data;
      CFG_B_COLS: size_bc = data;
      default: ;
    endcase
  endtask

  // Element value: mostly random, sometimes an extreme.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return VALUE_W'($urandom_range(0, 511) - 256);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic step_t item_step(input logic [MODE_W-1:0] mode, input int row,
                                      input int col, input logic [VALUE_W-1:0] value);
    step_t s;
    s = '{is_cfg: 1'b0, code: mode, row: POS_W'(row), col: POS_W'(col), value: value,
          typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx, input int data);
    step_t s;
    s = '{is_cfg: 1'b1, code: idx, row: '0, col: '0, value: VALUE_W'(data),
          typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t typed_step(input product_t want);
    step_t s;
    s = item_step(MODE_COMP, 0, 0, '0);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  // Random noise item: ignored mode, stray write or a stray compute.
  task automatic send_noise();
    logic [MODE_W-1:0] mode;
    mode = MODE_W'($urandom_range(0, 3));
    send_item(mode, POS_W'($urandom), POS_W'($urandom), pick_value(), 1'b0, '0);
  endtask

  // One random phase: set the sizes, load both matrices, compute, trail a few writes and maybe a second compute.
  task automatic run_phase(input bit pressure);
    logic [CFG_DATA_W-1:0] d_ar, d_ac, d_br, d_bc;
    int tail;
    case ($urandom_range(0, 9))
      0: begin
        d_ar = CFG_DATA_W'(8); d_ac = CFG_DATA_W'(8);
        d_br = CFG_DATA_W'(8); d_bc = CFG_DATA_W'(8);
      end
      1: begin
        d_ar = CFG_DATA_W'($urandom_range(0, 15)); d_ac = CFG_DATA_W'($urandom_range(0, 15));
        d_br = CFG_DATA_W'($urandom_range(0, 15)); d_bc = CFG_DATA_W'($urandom_range(0, 15));
      end
      2: begin
        d_ar = CFG_DATA_W'($urandom_range(1, 8)); d_ac = CFG_DATA_W'($urandom_range(1, 8));
        d_br = CFG_DATA_W'(d_ac % 8 + 1); d_bc = CFG_DATA_W'($urandom_range(1, 8));
      end
      default: begin
        d_ar = CFG_DATA_W'($urandom_range(1, 4)); d_ac = CFG_DATA_W'($urandom_range(1, 4));
        d_br = d_ac; d_bc = CFG_DATA_W'($urandom_range(1, 4));
      end
    endcase
    write_reg(CFG_A_ROWS, d_ar);
    write_reg(CFG_A_COLS, d_ac);
    write_reg(CFG_B_ROWS, d_br);
    write_reg(CFG_B_COLS, d_bc);
    calm = ($urandom_range(0, 3) == 0);

    for (int r = 0; r < eff_dim(d_ar); r++) begin
      for (int c = 0; c < eff_dim(d_ac); c++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_item(MODE_WR_A, POS_W'(r), POS_W'(c), pick_value(), 1'b0, '0);
      end
    end
    for (int r = 0; r < eff_dim(d_br); r++) begin
      for (int c = 0; c < eff_dim(d_bc); c++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_item(MODE_WR_B, POS_W'(r), POS_W'(c), pick_value(), 1'b0, '0);
      end
    end

    // The long receiver hold starts with this compute so that later writes back up.
    if (pressure) hold_req = 1'b1;
    send_item(MODE_COMP, '0, '0, '0, 1'b0, '0);
    tail = pressure ? 6 : $urandom_range(0, 3);
    repeat (tail)
      send_item(MODE_W'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom),
                pick_value(), 1'b0, '0);
    if ($urandom_range(0, 2) == 0) send_item(MODE_COMP, '0, '0, '0, 1'b0, '0);
  endtask

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    step_t plan [$];
    int phase;
    product_t one_by_one, size_error;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_WR_A;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_A_ROWS;
    cfg_ch.data  <= '0;
    foreach (elem_a[i]) begin
      elem_a[i] = '0;
      elem_b[i] = '0;
    end
    size_ar = DIM_RESET;
    size_ac = DIM_RESET;
    size_br = DIM_RESET;
    size_bc = DIM_RESET;

    // Most negative squared, with every size register at zero (treated as 1).
    one_by_one = '{row: '0, col: '0, product: 35'sd1073741824, mismatch: 1'b0, last: 1'b1};
    size_error = '{row: '0, col: '0, product: '0, mismatch: 1'b1, last: 1'b1};

    plan.push_back(item_step(MODE_COMP, 0, 0, '0));
    plan.push_back(item_step(MODE_WR_A, 0, 0, 16'h8000));
    plan.push_back(item_step(MODE_WR_B, 0, 0, 16'h8000));
    plan.push_back(item_step(MODE_WR_A, 7, 7, 16'h7FFF));
    plan.push_back(item_step(MODE_WR_B, 7, 7, 16'h7FFF));
    plan.push_back(item_step(MODE_WR_A, 0, 7, 16'h7FFF));
    plan.push_back(item_step(MODE_WR_B, 7, 0, 16'h8000));
    plan.push_back(item_step(MODE_WR_A, 3, 5, 16'h0100));
    plan.push_back(item_step(MODE_WR_B, 5, 2, 16'hFF00));
    plan.push_back(item_step(MODE_UNUSED, 5, 5, 16'h1234));
    plan.push_back(item_step(MODE_COMP, 0, 0, '0));
    plan.push_back(reg_step(CFG_A_ROWS, 0));
    plan.push_back(reg_step(CFG_A_COLS, 0));
    plan.push_back(reg_step(CFG_B_ROWS, 0));
    plan.push_back(reg_step(CFG_B_COLS, 0));
    plan.push_back(typed_step(one_by_one));
    plan.push_back(reg_step(CFG_A_COLS, 3));
    plan.push_back(reg_step(CFG_B_ROWS, 5));
    plan.push_back(typed_step(size_error));
    plan.push_back(reg_step(CFG_A_ROWS, 15));
    plan.push_back(reg_step(CFG_A_COLS, 9));
    plan.push_back(reg_step(CFG_B_ROWS, 15));
    plan.push_back(reg_step(CFG_B_COLS, 12));
    plan.push_back(item_step(MODE_COMP, 0, 0, '0));
    plan.push_back(reg_step(CFG_A_COLS, 8));
    plan.push_back(reg_step(CFG_B_ROWS, 7));
    plan.push_back(typed_step(size_error));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_reg(plan[i].code, plan[i].value[CFG_DATA_W-1:0]);
      else
        send_item(plan[i].code, plan[i].row, plan[i].col, plan[i].value,
                  plan[i].typed, plan[i].want);
    end

    phase = 0;
    while (n_items < 440) begin
      run_phase(phase == 2);
      phase++;
    end
    in_ch.valid <= 1'b0;

    while (products_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** matrix_multiply_engine_unit: PASSED **");
    else
      $display("** matrix_multiply_engine_unit: FAILED **");
    $finish;
  end

  // Result side: check each accepted item, then choose the next ready level.
  initial begin
    product_t got, want;
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{row: out_ch.out_row, col: out_ch.out_col, product: out_ch.product,
                mismatch: out_ch.mismatch, last: out_ch.last};
        if (products_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result row %0d col %0d product %0d mismatch %0b last %0b",
                   $time, got.row, got.col, got.product, got.mismatch, got.last);
        end else begin
          want = products_due.pop_front();
          if (got !== want) begin
            fail_count++;
            $display({"%0t: expected row %0d col %0d product %0d mismatch %0b last %0b,",
                      " got row %0d col %0d product %0d mismatch %0b last %0b"},
                     $time, want.row, want.col, want.product, want.mismatch, want.last,
                     got.row, got.col, got.product, got.mismatch, got.last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** matrix_multiply_engine_unit: FAILED **");
    $finish;
  end

endmodule
